[rtl/aes_block_cipher_defines.svh]
// assertion macros for the aes block cipher
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/aes_pkg.sv]
// shared types, constants and byte functions of the aes block cipher
package aes_pkg;

   localparam int SCHEDULE_WORDS = 60;
   localparam int BLOCK_COLUMNS  = 4;
   localparam int RK_AW = $clog2(SCHEDULE_WORDS);
   localparam int RK_CW = $clog2(SCHEDULE_WORDS + 1);

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_SIZE  = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD3 = 3'd4;

   // key size codes
   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;

   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   // schedule write port between key expansion and top level
   typedef struct packed {
      logic             we;
      logic [RK_AW-1:0] addr;
      logic [31:0]      data;
   } rk_wr_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

[rtl/aes_ram.sv]
// generic single-port-write ram with registered read
module aes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aes_key_expand.sv]
// key schedule expansion, one round-key word per cycle into the store
module aes_key_expand (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               key_size,
   input  logic [255:0]             key,
   output aes_pkg::rk_wr_type       rk_wr,
   output logic                     busy
);
   import aes_pkg::*;

   typedef enum logic {EXP_IDLE, EXP_RUN} exp_state_type;

   exp_state_type     state_ff, state_in;
   logic [RK_CW-1:0]  idx_ff, idx_in;
   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        rcon_ff, rcon_in;
   // last eight words kept in a sliding window, newest at index 0
   logic [31:0]       win_ff [8];
   logic [31:0]       win_in [8];
   logic [RK_CW-1:0]  total;
   logic [2:0]        nk_m1;
   logic [3:0]        nk;
   logic [31:0]       prev, back, t, word;
   logic              done;

   // key length and schedule length
   always_comb begin
      unique case (key_size)
         KEY_128: begin nk_m1 = 3'd3; total = RK_CW'(44); end
         KEY_192: begin nk_m1 = 3'd5; total = RK_CW'(52); end
         default: begin nk_m1 = 3'd7; total = RK_CW'(60); end
      endcase
      nk = {1'b0, nk_m1} + 4'd1;
   end

   // next schedule word
   always_comb begin
      prev = win_ff[0];
      back = win_ff[nk_m1];
      t    = prev;
      if (idx_ff < RK_CW'(nk)) begin
         word = key[255 - 32*idx_ff[2:0] -: 32];
      end else begin
         if (phase_ff == 3'd0) begin
            t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'h0};
         end else if (nk_m1 == 3'd7 && phase_ff == 3'd4) begin
            t = sub_word(prev);
         end
         word = back ^ t;
      end
      done = (idx_ff == total - RK_CW'(1));
   end

   // sequencer state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      rcon_in  = rcon_ff;
      win_in   = win_ff;
      priority if (start) begin
         state_in = EXP_RUN;
         idx_in   = '0;
         phase_in = '0;
         rcon_in  = 8'h01;
      end else if (state_ff == EXP_RUN) begin
         for (int k = 7; k > 0; k--) win_in[k] = win_ff[k-1];
         win_in[0] = word;
         idx_in    = idx_ff + RK_CW'(1);
         if (idx_ff >= RK_CW'(nk) && phase_ff == 3'd0) rcon_in = xtime(rcon_ff);
         phase_in  = (phase_ff == nk_m1) ? 3'd0 : phase_ff + 3'd1;
         if (done) state_in = EXP_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EXP_RUN;
         idx_ff   <= '0;
         phase_ff <= '0;
         rcon_ff  <= 8'h01;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         rcon_ff  <= rcon_in;
      end
      win_ff <= win_in;
   end

   assign rk_wr.we   = (state_ff == EXP_RUN) && !start;
   assign rk_wr.addr = idx_ff[RK_AW-1:0];
   assign rk_wr.data = word;
   assign busy       = (state_ff == EXP_RUN);

endmodule

[rtl/aes_round.sv]
// one aes round step: encrypt or decrypt round with key addition
module aes_round (
   input  logic         dec,
   input  logic         first,
   input  logic         last,
   input  logic [127:0] state_in_data,
   input  logic [127:0] round_key,
   output logic [127:0] state_out
);
   import aes_pkg::*;

   logic [7:0] s  [16];
   logic [7:0] sr [16];
   logic [7:0] sb [16];
   logic [7:0] ak [16];
   logic [7:0] mc [16];
   logic [7:0] rk [16];
   logic [7:0] o  [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i]  = state_in_data[127 - 8*i -: 8];
         rk[i] = round_key[127 - 8*i -: 8];
      end
      // shift rows then sub bytes (order commutes)
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (dec) sr[4*((c + r) % 4) + r] = s[4*c + r];
            else     sr[4*c + r] = s[4*((c + r) % 4) + r];
         end
      end
      for (int i = 0; i < 16; i++) sb[i] = dec ? INV_SBOX[sr[i]] : SBOX[sr[i]];
      // encrypt: mix then key; decrypt: key then inverse mix
      for (int i = 0; i < 16; i++) ak[i] = (dec ? sb[i] : sb[i]) ^ (dec ? rk[i] : 8'h00);
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (dec) begin
               mc[4*c+r] = gmul(ak[4*c + r], 8'h0e) ^ gmul(ak[4*c + (r+1)%4], 8'h0b)
                         ^ gmul(ak[4*c + (r+2)%4], 8'h0d) ^ gmul(ak[4*c + (r+3)%4], 8'h09);
            end else begin
               mc[4*c+r] = gmul(sb[4*c + r], 8'h02) ^ gmul(sb[4*c + (r+1)%4], 8'h03)
                         ^ sb[4*c + (r+2)%4] ^ sb[4*c + (r+3)%4];
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         priority if (first) o[i] = s[i] ^ rk[i];
         else if (last) o[i] = sb[i] ^ rk[i];
         else if (dec)  o[i] = mc[i];
         else           o[i] = mc[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = o[i];
   end

endmodule

[rtl/aes_block_cipher.sv]
// aes block cipher top level: registers, round-key store and round sequencer
// usage:
//   csr_ channel writes key_size (index 0) and key words (indexes 1 to 4);
//   each write to these indexes restarts key expansion, one schedule word
//   per cycle into a 60 x 32 store (44, 52 or 60 words); requests wait until
//   it finishes. req_ transfer carries req_type (0 encrypt, 1 decrypt) and
//   the block. a round key is four store words fetched one after another
//   through the single registered read port, then the round is applied; the
//   rounds number 10, 12 or 14 for the three key sizes, plus the initial key
//   addition, and rsp_valid rises after the last round. one block is worked
//   on at a time; the rsp_ register holds the result while the receiver
//   stalls, and req_ready stays low until the result has been transferred.
//   after the result transfer the sequencer returns to idle before the next
//   request is taken.
//   reset clears the registers to an all-zero 128-bit key and expands that
//   schedule (44 words) before the first request is taken.
module aes_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo
);
   import aes_pkg::*;
   `include "aes_block_cipher_defines.svh"

   typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_ROUND, ST_RESP} top_state_type;

   top_state_type     state_ff, state_in;
   logic [1:0]        key_size_ff;
   logic [255:0]      key_ff;
   logic              csr_fire, req_fire, rsp_fire;
   rk_wr_type         rk_wr;
   logic              exp_busy;
   logic [RK_AW-1:0]  rd_addr;
   logic [31:0]       rd_data;
   logic              dec_ff;
   logic [3:0]        round_ff, round_in;
   logic [3:0]        nr;
   logic [2:0]        word_ff, word_in;
   logic [95:0]       rk_acc_ff;
   logic [127:0]      state_ff_d, state_d_in;
   logic [127:0]      round_out;
   logic              first, last;
   logic [5:0]        key_idx;
   logic [127:0]      rsp_ff;
   logic              rsp_valid_ff;

   assign csr_fire = csr_valid && csr_ready;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= KEY_128;
         key_ff      <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_KEY_SIZE:  key_size_ff <= csr_data[1:0];
            CSR_KEY_WORD0: key_ff[255:192] <= csr_data;
            CSR_KEY_WORD1: key_ff[191:128] <= csr_data;
            CSR_KEY_WORD2: key_ff[127:64]  <= csr_data;
            CSR_KEY_WORD3: key_ff[63:0]    <= csr_data;
            default: ;
         endcase
      end
   end

   logic exp_start;
   assign exp_start = csr_fire && (csr_index <= CSR_KEY_WORD3);

   aes_key_expand u_expand (
      .clock    (clock),
      .reset    (reset),
      .start    (exp_start),
      .key_size (exp_start && csr_index == CSR_KEY_SIZE ? csr_data[1:0] : key_size_ff),
      .key      (key_ff),
      .rk_wr    (rk_wr),
      .busy     (exp_busy)
   );

   aes_ram #(.WIDTH(32), .DEPTH(SCHEDULE_WORDS)) u_rk_store (
      .clock   (clock),
      .wr_en   (rk_wr.we),
      .wr_addr (rk_wr.addr),
      .wr_data (rk_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // round count and current round-key word address
   always_comb begin
      unique case (key_size_ff)
         KEY_128: nr = 4'd10;
         KEY_192: nr = 4'd12;
         default: nr = 4'd14;
      endcase
      key_idx = dec_ff ? 6'(nr - round_ff) : 6'(round_ff);
      rd_addr = RK_AW'({key_idx, 2'b00} + 8'(word_ff[1:0]));
      first   = (round_ff == 4'd0);
      last    = (round_ff == nr);
   end

   aes_round u_round (
      .dec           (dec_ff),
      .first         (first),
      .last          (last),
      .state_in_data (state_ff_d),
      .round_key     ({rk_acc_ff, rd_data}),
      .state_out     (round_out)
   );

   // sequencer: fetch four key words, then apply one round
   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      word_in    = word_ff;
      state_d_in = state_ff_d;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in   = ST_FETCH;
               round_in   = '0;
               word_in    = '0;
               state_d_in = {req_block_hi, req_block_lo};
            end
         end
         ST_FETCH: begin
            word_in = word_ff + 3'd1;
            if (word_ff == 3'd3) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_d_in = round_out;
            word_in    = '0;
            if (last) state_in = ST_RESP;
            else begin
               round_in = round_ff + 4'd1;
               state_in = ST_FETCH;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         word_ff      <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         if (state_ff == ST_ROUND && last) rsp_valid_ff <= 1'b1;
         else if (rsp_fire) rsp_valid_ff <= 1'b0;
      end
      state_ff_d <= state_d_in;
      if (req_fire) dec_ff <= req_type;
      // collect key words as they arrive from the store
      if (state_ff == ST_FETCH && word_ff != 3'd0) rk_acc_ff <= {rk_acc_ff[63:0], rd_data};
      if (state_ff == ST_ROUND && last) rsp_ff <= round_out;
   end

   assign req_ready     = (state_ff == ST_IDLE) && !exp_busy && !exp_start && !rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = rsp_ff[127:64];
   assign rsp_result_lo = rsp_ff[63:0];

   `AES_ASSERT_IMPL(a_no_req_during_expand, clock, reset, exp_busy, !req_ready,
      "request taken during key expansion")
   `AES_ASSERT_NEXT(a_rsp_after_last, clock, reset, state_ff == ST_ROUND && last,
      rsp_valid, "result not presented after last round")
   `AES_ASSERT_IMPL(a_fetch_bound, clock, reset, state_ff == ST_FETCH, word_ff <= 3'd3,
      "key word counter overran")

endmodule
